// ===== rtl/core/u8dfa_pkg.sv =====
// Package for the UTF-8 validating decoder: automaton state type, byte class
// codes, class lookup, transition function and the result record.
// No dependencies.
`default_nettype none

package u8dfa_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned ACCUM_W = 21;
  localparam int unsigned CP_W    = 16;
  localparam int unsigned PAYLOAD_BITS = 6;

  // Automaton states; ST_ACCEPT and ST_REJECT are the two named states,
  // the rest track the position inside a multi-byte sequence.
  typedef enum logic [8:0] {
    ST_ACCEPT = 9'b000000001,
    ST_REJECT = 9'b000000010,
    ST_S2     = 9'b000000100,
    ST_S3     = 9'b000001000,
    ST_S4     = 9'b000010000,
    ST_S5     = 9'b000100000,
    ST_S6     = 9'b001000000,
    ST_S7     = 9'b010000000,
    ST_S8     = 9'b100000000
  } dfa_state_t;

  typedef logic [CLASS_W-1:0] byte_class_t;

  localparam byte_class_t CLS_ASCII    = 4'd0;
  localparam byte_class_t CLS_CONT_LO  = 4'd1;   // 80..8f
  localparam byte_class_t CLS_LEAD2    = 4'd2;   // c2..df
  localparam byte_class_t CLS_LEAD3    = 4'd3;   // e1..ec, ee, ef
  localparam byte_class_t CLS_ED       = 4'd4;
  localparam byte_class_t CLS_F4       = 4'd5;
  localparam byte_class_t CLS_F1_F3    = 4'd6;
  localparam byte_class_t CLS_CONT_HI  = 4'd7;   // a0..bf
  localparam byte_class_t CLS_INVALID  = 4'd8;   // c0, c1, f5..ff
  localparam byte_class_t CLS_CONT_MID = 4'd9;   // 90..9f
  localparam byte_class_t CLS_E0       = 4'd10;
  localparam byte_class_t CLS_F0       = 4'd11;

  typedef struct packed {
    logic            char_valid;
    logic [CP_W-1:0] code_point;
    logic            rejected;
  } result_t;

  function automatic byte_class_t byte_class(input logic [BYTE_W-1:0] b);
    byte_class_t c;
    case (b) inside
      [8'h00:8'h7f]:                 c = CLS_ASCII;
      [8'h80:8'h8f]:                 c = CLS_CONT_LO;
      [8'h90:8'h9f]:                 c = CLS_CONT_MID;
      [8'ha0:8'hbf]:                 c = CLS_CONT_HI;
      [8'hc2:8'hdf]:                 c = CLS_LEAD2;
      8'he0:                         c = CLS_E0;
      [8'he1:8'hec], 8'hee, 8'hef:   c = CLS_LEAD3;
      8'hed:                         c = CLS_ED;
      8'hf0:                         c = CLS_F0;
      [8'hf1:8'hf3]:                 c = CLS_F1_F3;
      8'hf4:                         c = CLS_F4;
      default:                       c = CLS_INVALID;
    endcase
    return c;
  endfunction

  function automatic dfa_state_t next_state(input dfa_state_t st, input byte_class_t c);
    dfa_state_t n;
    n = ST_REJECT;
    unique case (st)
      ST_ACCEPT: begin
        case (c) inside
          CLS_ASCII:   n = ST_ACCEPT;
          CLS_LEAD2:   n = ST_S2;
          CLS_LEAD3:   n = ST_S3;
          CLS_ED:      n = ST_S5;
          CLS_F4:      n = ST_S8;
          CLS_F1_F3:   n = ST_S7;
          CLS_E0:      n = ST_S4;
          CLS_F0:      n = ST_S6;
          default:     n = ST_REJECT;
        endcase
      end
      ST_REJECT: n = ST_REJECT;
      ST_S2: begin
        case (c) inside
          CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI: n = ST_ACCEPT;
          default:                                n = ST_REJECT;
        endcase
      end
      ST_S3: begin
        case (c) inside
          CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI: n = ST_S2;
          default:                                n = ST_REJECT;
        endcase
      end
      ST_S4: begin
        case (c) inside
          CLS_CONT_HI: n = ST_S2;
          default:     n = ST_REJECT;
        endcase
      end
      ST_S5: begin
        case (c) inside
          CLS_CONT_LO, CLS_CONT_MID: n = ST_S2;
          default:                   n = ST_REJECT;
        endcase
      end
      ST_S6: begin
        case (c) inside
          CLS_CONT_MID, CLS_CONT_HI: n = ST_S3;
          default:                   n = ST_REJECT;
        endcase
      end
      ST_S7: begin
        case (c) inside
          CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI: n = ST_S3;
          default:                                n = ST_REJECT;
        endcase
      end
      ST_S8: begin
        case (c) inside
          CLS_CONT_LO: n = ST_S3;
          default:     n = ST_REJECT;
        endcase
      end
      default: n = ST_REJECT;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8_dfa_decoder.sv =====
// Top level of the UTF-8 validating decoder: input register, decode step,
// result register. Depends on u8dfa_pkg and u8dfa_step.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------
//   in_     | input     | in_valid/in_stall  | data_byte[7:0], string_start
//   out_    | output    | out_valid/out_stall| char_valid, code_point[15:0], rejected
//
// One byte per clock sustained while out_stall is low; each byte gives exactly one result.
// The byte lands in the input register, then one pass of class lookup,
// transition and accumulator shift loads the result register.
// The automaton state updates only when a result is loaded, so a single pass
// of that logic bounds the rate.
// rst_n (synchronous, active low) clears both valid flags and puts the
// automaton in the accept state with an empty accumulator.
// out_stall holds the result register; the input register keeps taking a byte
// until it too is full, then in_stall rises.
`default_nettype none

module utf8_dfa_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [u8dfa_pkg::BYTE_W-1:0]   in_data_byte,
  input  wire logic                           in_string_start,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_char_valid,
  output logic [u8dfa_pkg::CP_W-1:0]          out_code_point,
  output logic                                out_rejected
);

  // input register
  logic                         in_vld_r;
  logic [u8dfa_pkg::BYTE_W-1:0] byte_r;
  logic                         start_r;

  // automaton state
  u8dfa_pkg::dfa_state_t         state_r, state_nxt;
  logic [u8dfa_pkg::ACCUM_W-1:0] accum_r, accum_nxt;

  // result register
  logic                          out_vld_r;
  u8dfa_pkg::result_t            res_r, res_nxt;

  u8dfa_pkg::dfa_state_t         cur_state;
  logic [u8dfa_pkg::ACCUM_W-1:0] cur_accum;

  logic out_hold;   // result register occupied and not taken
  logic advance;    // input register moves into result register
  logic in_take;    // input transfer

  assign out_hold = out_vld_r && out_stall;
  assign advance  = in_vld_r && !out_hold;
  assign in_stall = in_vld_r && out_hold;
  assign in_take  = in_valid && !in_stall;

  // string start clears the automaton ahead of this byte
  assign cur_state = start_r ? u8dfa_pkg::ST_ACCEPT : state_r;
  assign cur_accum = start_r ? '0 : accum_r;

  u8dfa_step u_step (
    .cur_state (cur_state),
    .cur_accum (cur_accum),
    .data_byte (byte_r),
    .nxt_state (state_nxt),
    .nxt_accum (accum_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r  <= in_data_byte;
      start_r <= in_string_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u8dfa_pkg::ST_ACCEPT;
      accum_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      accum_r <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_hold) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_char_valid = res_r.char_valid;
  assign out_code_point = res_r.code_point;
  assign out_rejected   = res_r.rejected;

`ifndef SYNTHESIS
  // a completed character never comes with the reject flag
  a_valid_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_char_valid && out_rejected))
    else $error("char_valid and rejected both set");

  // code point field is zero unless a character completed
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_char_valid) |-> (out_code_point == '0))
    else $error("code_point nonzero without char_valid");

  // automaton must not move while a result waits
  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(state_r) && $stable(accum_r))
    else $error("automaton advanced during output stall");

  // input stall only when a byte is parked in the input register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r))
    else $error("in_stall without full pipeline");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/u8dfa_step.sv =====
// One decode step: byte class lookup, state transition, accumulator update
// and result formation. Combinational. Depends on u8dfa_pkg.
`default_nettype none

module u8dfa_step (
  input  wire u8dfa_pkg::dfa_state_t           cur_state,
  input  wire logic [u8dfa_pkg::ACCUM_W-1:0]   cur_accum,
  input  wire logic [u8dfa_pkg::BYTE_W-1:0]    data_byte,
  output u8dfa_pkg::dfa_state_t                nxt_state,
  output logic [u8dfa_pkg::ACCUM_W-1:0]        nxt_accum,
  output u8dfa_pkg::result_t                   result
);

  u8dfa_pkg::byte_class_t      cls;
  logic [u8dfa_pkg::BYTE_W-1:0] lead_mask;
  logic                         fits;

  always_comb begin
    cls       = u8dfa_pkg::byte_class(data_byte);
    lead_mask = 8'hff >> cls;   // zero for classes 8 and up
    if (cur_state != u8dfa_pkg::ST_ACCEPT) begin
      nxt_accum = {cur_accum[u8dfa_pkg::ACCUM_W-u8dfa_pkg::PAYLOAD_BITS-1:0],
                   data_byte[u8dfa_pkg::PAYLOAD_BITS-1:0]};
    end else begin
      nxt_accum = {{(u8dfa_pkg::ACCUM_W-u8dfa_pkg::BYTE_W){1'b0}}, lead_mask & data_byte};
    end
    nxt_state = u8dfa_pkg::next_state(cur_state, cls);
    fits      = (nxt_accum[u8dfa_pkg::ACCUM_W-1:u8dfa_pkg::CP_W] == '0);
    result.char_valid = (nxt_state == u8dfa_pkg::ST_ACCEPT) && fits;
    result.code_point = result.char_valid ? nxt_accum[u8dfa_pkg::CP_W-1:0] : '0;
    result.rejected   = (nxt_state == u8dfa_pkg::ST_REJECT);
  end

endmodule

`default_nettype wire
